// File: rtl/mcpf_pkg.sv
// ----------------------------------------------------------------------------
// MQTT control packet framer package
// Item types, job descriptor passed from the classifier to the byte
// sequencer, byte slot codes and protocol constants.
// ----------------------------------------------------------------------------
package mcpf_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int LEN_W       = 16;
    localparam int PKT_LEN_W   = 18;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_ALIVE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUB_ID     = 1'b1;

    localparam logic [15:0] KEEP_ALIVE_RESET = 16'h0064;
    localparam logic [15:0] SUB_ID_RESET     = 16'h0001;

    localparam logic [2:0] CMD_CONNECT     = 3'd0;
    localparam logic [2:0] CMD_SUBSCRIBE   = 3'd1;
    localparam logic [2:0] CMD_UNSUBSCRIBE = 3'd2;
    localparam logic [2:0] CMD_PUBLISH     = 3'd3;
    localparam logic [2:0] CMD_PINGREQ     = 3'd4;
    localparam logic [2:0] CMD_DISCONNECT  = 3'd5;
    localparam logic [2:0] CMD_DATA        = 3'd6;

    localparam logic [7:0] TYPE_CONNECT     = 8'h10;
    localparam logic [7:0] TYPE_SUBSCRIBE   = 8'h82;
    localparam logic [7:0] TYPE_UNSUBSCRIBE = 8'hA2;
    localparam logic [7:0] TYPE_PUBLISH     = 8'h30;
    localparam logic [7:0] TYPE_PINGREQ     = 8'hC0;
    localparam logic [7:0] TYPE_DISCONNECT  = 8'hE0;

    localparam logic [7:0] NAME_LEN_HI = 8'h00;
    localparam logic [7:0] NAME_LEN_LO = 8'h04;
    localparam logic [7:0] CHAR_M      = 8'h4D;
    localparam logic [7:0] CHAR_Q      = 8'h51;
    localparam logic [7:0] CHAR_T      = 8'h54;
    localparam logic [7:0] PROTO_LEVEL = 8'h04;
    localparam logic [7:0] FLAG_CLEAN  = 8'h02;
    localparam logic [7:0] FLAG_USER   = 8'h80;
    localparam logic [7:0] FLAG_PASS   = 8'h40;

    localparam logic [1:0] QOS_MAX = 2'd2;

    typedef enum logic [4:0] {
        SLOT_TYPE,
        SLOT_RL0,
        SLOT_RL1,
        SLOT_RL2,
        SLOT_NAME_LEN_HI,
        SLOT_NAME_LEN_LO,
        SLOT_NAME_M,
        SLOT_NAME_Q,
        SLOT_NAME_T1,
        SLOT_NAME_T2,
        SLOT_LEVEL,
        SLOT_FLAGS,
        SLOT_HEAD_HI,
        SLOT_HEAD_LO,
        SLOT_SEG_HI,
        SLOT_SEG_LO,
        SLOT_DATA,
        SLOT_TAIL_HI,
        SLOT_TAIL_LO,
        SLOT_TAIL_QOS
    } t_slot;

    localparam int NUM_SLOTS = 20;

    typedef struct packed {
        logic [2:0]       command;
        logic [LEN_W-1:0] len_a;
        logic [LEN_W-1:0] len_b;
        logic [LEN_W-1:0] len_c;
        logic [1:0]       qos_level;
        logic [7:0]       data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]           out_byte;
        logic                 last_byte;
        logic [PKT_LEN_W-1:0] packet_length;
    } t_out_item;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] slots;
        logic [7:0]           lead_byte;
        logic [PKT_LEN_W-1:0] rem_len;
        logic [7:0]           flags;
        logic [15:0]          head_word;
        logic [LEN_W-1:0]     seg_len;
        logic [15:0]          tail_word;
        logic [1:0]           tail_qos;
        logic                 finish;
    } t_job;

endpackage

// File: rtl/mcpf_front.sv
// ----------------------------------------------------------------------------
// MQTT framer front end
// Takes input items, tracks the open packet's segments and turns each item
// into a job descriptor naming the bytes that the back end must send.
// ----------------------------------------------------------------------------
module mcpf_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  mcpf_pkg::t_in_item                 i_item,
    input  logic                               i_cfg_we,
    input  logic [mcpf_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [mcpf_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                               i_job_full,
    output logic                               o_job_push,
    output mcpf_pkg::t_job                     o_job
);
    import mcpf_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CID,
        PH_USER,
        PH_PASS,
        PH_TOPIC,
        PH_MSG
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [LEN_W-1:0] r_remaining, n_remaining;
    logic [LEN_W-1:0] r_len_b, n_len_b;
    logic [LEN_W-1:0] r_len_c, n_len_c;
    logic [2:0]       r_kind, n_kind;
    logic [1:0]       r_qos, n_qos;
    logic [15:0]      r_pub_id, n_pub_id;
    logic [15:0]      r_keep_alive;
    logic [15:0]      r_sub_id;

    logic             accept;
    logic [1:0]       qos_eff;
    logic [PKT_LEN_W-1:0] rl;
    t_job             job;
    logic             job_push;

    assign accept  = i_push & ~i_job_full;
    assign qos_eff = (i_item.qos_level > QOS_MAX) ? QOS_MAX : i_item.qos_level;

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_len_b     = r_len_b;
        n_len_c     = r_len_c;
        n_kind      = r_kind;
        n_qos       = r_qos;
        n_pub_id    = r_pub_id;
        job         = '0;
        job_push    = 1'b0;
        rl          = '0;

        if (accept) begin
            unique case (i_item.command) inside
                CMD_DATA: begin
                    if (r_phase != PH_IDLE && r_remaining != '0) begin
                        job_push              = 1'b1;
                        job.slots[SLOT_DATA]  = 1'b1;
                        job.lead_byte         = i_item.data_byte;
                        n_remaining           = r_remaining - LEN_W'(1);
                    end
                end
                CMD_CONNECT, CMD_SUBSCRIBE, CMD_UNSUBSCRIBE, CMD_PUBLISH,
                CMD_PINGREQ, CMD_DISCONNECT: begin
                    job_push             = 1'b1;
                    n_kind               = i_item.command;
                    n_qos                = qos_eff;
                    n_len_b              = i_item.len_b;
                    n_len_c              = i_item.len_c;
                    n_phase              = PH_IDLE;
                    n_remaining          = '0;
                    job.slots[SLOT_TYPE] = 1'b1;
                    job.slots[SLOT_RL0]  = 1'b1;
                    job.seg_len          = i_item.len_a;
                    unique case (i_item.command) inside
                        CMD_CONNECT: begin
                            rl = PKT_LEN_W'(12) + PKT_LEN_W'(i_item.len_a);
                            job.flags = FLAG_CLEAN;
                            if (i_item.len_b != '0) begin
                                rl        = rl + PKT_LEN_W'(i_item.len_b) + PKT_LEN_W'(2);
                                job.flags = job.flags | FLAG_USER;
                            end
                            if (i_item.len_c != '0) begin
                                rl        = rl + PKT_LEN_W'(i_item.len_c) + PKT_LEN_W'(2);
                                job.flags = job.flags | FLAG_PASS;
                            end
                            job.lead_byte               = TYPE_CONNECT;
                            job.head_word               = r_keep_alive;
                            job.slots[SLOT_NAME_LEN_HI] = 1'b1;
                            job.slots[SLOT_NAME_LEN_LO] = 1'b1;
                            job.slots[SLOT_NAME_M]      = 1'b1;
                            job.slots[SLOT_NAME_Q]      = 1'b1;
                            job.slots[SLOT_NAME_T1]     = 1'b1;
                            job.slots[SLOT_NAME_T2]     = 1'b1;
                            job.slots[SLOT_LEVEL]       = 1'b1;
                            job.slots[SLOT_FLAGS]       = 1'b1;
                            job.slots[SLOT_HEAD_HI]     = 1'b1;
                            job.slots[SLOT_HEAD_LO]     = 1'b1;
                            job.slots[SLOT_SEG_HI]      = 1'b1;
                            job.slots[SLOT_SEG_LO]      = 1'b1;
                            n_phase                     = PH_CID;
                            n_remaining                 = i_item.len_a;
                        end
                        CMD_SUBSCRIBE, CMD_UNSUBSCRIBE: begin
                            rl = PKT_LEN_W'(4) + PKT_LEN_W'(i_item.len_a);
                            if (i_item.command == CMD_SUBSCRIBE) begin
                                rl            = rl + PKT_LEN_W'(1);
                                job.lead_byte = TYPE_SUBSCRIBE;
                            end else begin
                                job.lead_byte = TYPE_UNSUBSCRIBE;
                            end
                            job.head_word           = r_sub_id;
                            job.slots[SLOT_HEAD_HI] = 1'b1;
                            job.slots[SLOT_HEAD_LO] = 1'b1;
                            job.slots[SLOT_SEG_HI]  = 1'b1;
                            job.slots[SLOT_SEG_LO]  = 1'b1;
                            n_phase                 = PH_TOPIC;
                            n_remaining             = i_item.len_a;
                        end
                        CMD_PUBLISH: begin
                            rl = PKT_LEN_W'(2) + PKT_LEN_W'(i_item.len_a)
                               + PKT_LEN_W'(i_item.len_b);
                            if (qos_eff != '0) begin
                                rl = rl + PKT_LEN_W'(2);
                            end
                            job.lead_byte          = TYPE_PUBLISH | {5'b0, qos_eff, 1'b0};
                            job.slots[SLOT_SEG_HI] = 1'b1;
                            job.slots[SLOT_SEG_LO] = 1'b1;
                            n_phase                = PH_TOPIC;
                            n_remaining            = i_item.len_a;
                        end
                        default: begin
                            job.lead_byte = (i_item.command == CMD_PINGREQ) ?
                                            TYPE_PINGREQ : TYPE_DISCONNECT;
                            job.finish    = 1'b1;
                        end
                    endcase
                    job.rem_len         = rl;
                    job.slots[SLOT_RL1] = |rl[PKT_LEN_W-1:7];
                    job.slots[SLOT_RL2] = |rl[PKT_LEN_W-1:14];
                end
                default: begin
                end
            endcase

            // close finished segments: prefixes, trailers and packet end
            if (job_push && n_phase != PH_IDLE && n_remaining == '0) begin
                unique case (n_phase)
                    PH_CID: begin
                        if (n_len_b != '0) begin
                            job.tail_word           = n_len_b;
                            job.slots[SLOT_TAIL_HI] = 1'b1;
                            job.slots[SLOT_TAIL_LO] = 1'b1;
                            n_phase                 = PH_USER;
                            n_remaining             = n_len_b;
                        end else if (n_len_c != '0) begin
                            job.tail_word           = n_len_c;
                            job.slots[SLOT_TAIL_HI] = 1'b1;
                            job.slots[SLOT_TAIL_LO] = 1'b1;
                            n_phase                 = PH_PASS;
                            n_remaining             = n_len_c;
                        end else begin
                            job.finish = 1'b1;
                        end
                    end
                    PH_USER: begin
                        if (n_len_c != '0) begin
                            job.tail_word           = n_len_c;
                            job.slots[SLOT_TAIL_HI] = 1'b1;
                            job.slots[SLOT_TAIL_LO] = 1'b1;
                            n_phase                 = PH_PASS;
                            n_remaining             = n_len_c;
                        end else begin
                            job.finish = 1'b1;
                        end
                    end
                    PH_TOPIC: begin
                        if (n_kind == CMD_SUBSCRIBE) begin
                            job.tail_qos             = n_qos;
                            job.slots[SLOT_TAIL_QOS] = 1'b1;
                            job.finish               = 1'b1;
                        end else if (n_kind == CMD_PUBLISH) begin
                            if (n_qos != '0) begin
                                job.tail_word           = r_pub_id;
                                job.slots[SLOT_TAIL_HI] = 1'b1;
                                job.slots[SLOT_TAIL_LO] = 1'b1;
                                n_pub_id                = r_pub_id + 16'd1;
                            end
                            n_phase     = PH_MSG;
                            n_remaining = n_len_b;
                            if (n_len_b == '0) begin
                                job.finish = 1'b1;
                            end
                        end else begin
                            job.finish = 1'b1;
                        end
                    end
                    default: begin
                        job.finish = 1'b1;
                    end
                endcase
                if (job.finish) begin
                    n_phase     = PH_IDLE;
                    n_remaining = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_remaining  <= '0;
            r_len_b      <= '0;
            r_len_c      <= '0;
            r_kind       <= CMD_CONNECT;
            r_qos        <= '0;
            r_pub_id     <= '0;
            r_keep_alive <= KEEP_ALIVE_RESET;
            r_sub_id     <= SUB_ID_RESET;
        end else begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_len_b     <= n_len_b;
            r_len_c     <= n_len_c;
            r_kind      <= n_kind;
            r_qos       <= n_qos;
            r_pub_id    <= n_pub_id;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_KEEP_ALIVE: r_keep_alive <= i_cfg_wdata;
                    CFG_SUB_ID:     r_sub_id     <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_job_push = job_push;
    assign o_job      = job;

endmodule

// File: rtl/mcpf_job_fifo.sv
// ----------------------------------------------------------------------------
// MQTT framer job queue
// Show-ahead queue of job descriptors between the front and back ends.
// ----------------------------------------------------------------------------
module mcpf_job_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mcpf_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output mcpf_pkg::t_job o_job,
    output logic           o_empty
);
    import mcpf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr;
    logic             rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign wr      = i_push & ~o_full;
    assign rd      = i_pop & ~o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (wr && !rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd && !wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: rtl/mcpf_back.sv
// ----------------------------------------------------------------------------
// MQTT framer back end
// Walks the byte slots of the head job, one byte per cycle while the result
// buffer has room, counts packet bytes and feeds that two-entry result buffer.
// ----------------------------------------------------------------------------
module mcpf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mcpf_pkg::t_job      i_job,
    input  logic                i_job_empty,
    output logic                o_job_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output mcpf_pkg::t_out_item o_result
);
    import mcpf_pkg::*;

    logic [NUM_SLOTS-1:0] r_done;
    logic [PKT_LEN_W-1:0] r_count;
    t_out_item            r_buf [2];
    logic                 r_wr_ptr;
    logic                 r_rd_ptr;
    logic [1:0]           r_buf_count;

    logic [NUM_SLOTS-1:0] rem_mask;
    logic [NUM_SLOTS-1:0] sel_bit;
    t_slot                sel;
    logic                 job_last;
    logic                 emit;
    logic                 out_rd;
    logic [7:0]           sel_byte;
    logic [PKT_LEN_W-1:0] cnt;
    t_out_item            item;

    assign rem_mask = i_job.slots & ~r_done;

    always_comb begin
        sel = SLOT_TYPE;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (rem_mask[i]) begin
                sel = t_slot'(i);
            end
        end
    end

    assign sel_bit  = {{(NUM_SLOTS-1){1'b0}}, 1'b1} << sel;
    assign job_last = ((rem_mask & ~sel_bit) == '0);
    assign emit     = ~i_job_empty & (r_buf_count != 2'd2);
    assign out_rd   = i_pop & ~o_empty;

    always_comb begin
        unique case (sel) inside
            SLOT_TYPE, SLOT_DATA: sel_byte = i_job.lead_byte;
            SLOT_RL0:         sel_byte = {|i_job.rem_len[PKT_LEN_W-1:7], i_job.rem_len[6:0]};
            SLOT_RL1:         sel_byte = {|i_job.rem_len[PKT_LEN_W-1:14], i_job.rem_len[13:7]};
            SLOT_RL2:         sel_byte = 8'(i_job.rem_len[PKT_LEN_W-1:14]);
            SLOT_NAME_LEN_HI: sel_byte = NAME_LEN_HI;
            SLOT_NAME_LEN_LO: sel_byte = NAME_LEN_LO;
            SLOT_NAME_M:      sel_byte = CHAR_M;
            SLOT_NAME_Q:      sel_byte = CHAR_Q;
            SLOT_NAME_T1,
            SLOT_NAME_T2:     sel_byte = CHAR_T;
            SLOT_LEVEL:       sel_byte = PROTO_LEVEL;
            SLOT_FLAGS:       sel_byte = i_job.flags;
            SLOT_HEAD_HI:     sel_byte = i_job.head_word[15:8];
            SLOT_HEAD_LO:     sel_byte = i_job.head_word[7:0];
            SLOT_SEG_HI:      sel_byte = i_job.seg_len[15:8];
            SLOT_SEG_LO:      sel_byte = i_job.seg_len[7:0];
            SLOT_TAIL_HI:     sel_byte = i_job.tail_word[15:8];
            SLOT_TAIL_LO:     sel_byte = i_job.tail_word[7:0];
            SLOT_TAIL_QOS:    sel_byte = {6'b0, i_job.tail_qos};
            default:          sel_byte = '0;
        endcase
    end

    assign cnt = ((sel == SLOT_TYPE) ? '0 : r_count) + PKT_LEN_W'(1);

    always_comb begin
        item.out_byte      = sel_byte;
        item.last_byte     = job_last & i_job.finish;
        item.packet_length = (job_last & i_job.finish) ? cnt : '0;
    end

    assign o_job_pop = emit & job_last;
    assign o_empty   = (r_buf_count == '0);
    assign o_result  = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_count     <= '0;
            r_wr_ptr    <= 1'b0;
            r_rd_ptr    <= 1'b0;
            r_buf_count <= '0;
        end else begin
            if (emit) begin
                r_count  <= cnt;
                r_wr_ptr <= ~r_wr_ptr;
                r_done   <= job_last ? '0 : (r_done | sel_bit);
            end
            if (out_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (emit && !out_rd) begin
                r_buf_count <= r_buf_count + 2'd1;
            end else if (out_rd && !emit) begin
                r_buf_count <= r_buf_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_buf[r_wr_ptr] <= item;
        end
    end

endmodule

// File: rtl/mqtt_control_packet_framer.sv
// ----------------------------------------------------------------------------
// MQTT control packet framer
// Frames MQTT 3.1.1 control packets into a byte stream.
//
// Input channel (push/full): start items name a packet kind and its segment
// lengths; data items carry string bytes in segment order. Data items that
// arrive with no open segment are taken and dropped; a start item abandons
// any open packet.
// Result channel (empty/pop): one packet byte per transfer, last_byte and
// packet_length flag the final byte of each packet.
// Configuration: i_cfg_we writes keep alive (index 0) or the subscribe packet
// identifier (index 1); write only while the block is idle.
// Throughput: one input item per cycle while the job queue has room. The byte
// sequencer sends one byte per cycle while the result buffer has room. A data
// item yields one to three bytes (its byte plus any length prefix, QoS byte or
// identifier that falls due) and a start item its header bytes (2 to 18). The
// first byte of an item goes through the job queue and then the result buffer.
// Reset clears the open packet and the publish identifier, and loads keep
// alive 100 and packet identifier 1. When the receiver stalls, the result
// buffer and job queue fill and full rises; nothing is lost.
// ----------------------------------------------------------------------------
module mqtt_control_packet_framer #(
    parameter int JOB_DEPTH = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  mcpf_pkg::t_in_item               i_item,
    input  logic                             pop,
    output logic                             empty,
    output mcpf_pkg::t_out_item              o_result,
    input  logic                             i_cfg_we,
    input  logic [mcpf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mcpf_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import mcpf_pkg::*;

    t_job job_in;
    t_job job_out;
    logic job_push;
    logic job_full;
    logic job_pop;
    logic job_empty;

    mcpf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_job_full  (job_full),
        .o_job_push  (job_push),
        .o_job       (job_in)
    );

    mcpf_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_empty (job_empty)
    );

    mcpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

    assign full = job_full;

endmodule

// File: verif/tb_mqtt_control_packet_framer.sv
// ----------------------------------------------------------------------------
// MQTT control packet framer testbench
// Drives start and data items through the push/full side and pops framed
// bytes from the empty/pop side. A scoreboard class predicts every packet
// byte, the last-byte flag and the packet length, and compares each popped
// byte in order. Directed packets cover empty segments, maximum lengths,
// QoS clamping, stray data and reserved commands. Random packets follow with
// both registers reprogrammed between phases under varying idle and stall
// rates.
// ----------------------------------------------------------------------------
module tb_mqtt_control_packet_framer;

    timeunit 1ns;
    timeprecision 1ps;

    import mcpf_pkg::*;

    localparam logic [2:0] CMD_RESERVED = 3'd7;
    localparam logic [7:0] REM_LEN_NONE = 8'h00;
    localparam int         BURST_CAP    = 24;
    localparam int         DRAIN_CYCLES = 40;

    typedef enum logic [3:0] {
        SEG_IDLE,
        SEG_CLIENT_ID,
        SEG_USER,
        SEG_PASS,
        SEG_TOPIC,
        SEG_MESSAGE
    } t_seg;

    class framer_scoreboard;
        t_out_item       bytes_due[$];
        logic [15:0]     keep_alive;
        logic [15:0]     sub_id;
        t_seg            seg;
        logic [15:0]     seg_left;
        logic [15:0]     user_len;
        logic [15:0]     pass_len;
        logic [2:0]      kind;
        logic [1:0]      qos_held;
        logic [15:0]     pub_id;
        logic [17:0]     emitted;
        int              burst;
        int              errors;
        int              matched;

        function new();
            keep_alive = KEEP_ALIVE_RESET;
            sub_id     = SUB_ID_RESET;
            seg        = SEG_IDLE;
            seg_left   = '0;
            user_len   = '0;
            pass_len   = '0;
            kind       = '0;
            qos_held   = '0;
            pub_id     = '0;
            emitted    = '0;
            errors     = 0;
            matched    = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
            if (idx == CFG_KEEP_ALIVE)
                keep_alive = value;
            else
                sub_id = value;
        endfunction

        function int pending();
            return bytes_due.size();
        endfunction

        function void emit(logic [7:0] value);
            t_out_item e;
            if (burst >= BURST_CAP)
                return;
            e.out_byte      = value;
            e.last_byte     = 1'b0;
            e.packet_length = '0;
            bytes_due.push_back(e);
            burst++;
            emitted++;
        endfunction

        function void emit16(logic [15:0] value);
            emit(value[15:8]);
            emit(value[7:0]);
        endfunction

        function void emit_rem_len(int len);
            logic [7:0] group;
            do begin
                group = 8'(len % 128);
                len   = len / 128;
                if (len > 0)
                    group[7] = 1'b1;
                emit(group);
            end while (len > 0);
        endfunction

        function void close_packet();
            t_out_item tail;
            if (burst > 0) begin
                tail               = bytes_due.pop_back();
                tail.last_byte     = 1'b1;
                tail.packet_length = emitted;
                bytes_due.push_back(tail);
            end
            seg      = SEG_IDLE;
            seg_left = '0;
        endfunction

        function void advance_segments();
            while (seg != SEG_IDLE && seg_left == 0) begin
                case (seg)
                    SEG_CLIENT_ID: begin
                        seg = SEG_USER;
                        if (user_len > 0) begin
                            emit16(user_len);
                            seg_left = user_len;
                        end
                    end
                    SEG_USER: begin
                        seg = SEG_PASS;
                        if (pass_len > 0) begin
                            emit16(pass_len);
                            seg_left = pass_len;
                        end
                    end
                    SEG_TOPIC: begin
                        if (kind == CMD_SUBSCRIBE) begin
                            emit({6'd0, qos_held});
                            close_packet();
                        end else if (kind == CMD_PUBLISH) begin
                            if (qos_held > 0) begin
                                emit16(pub_id);
                                pub_id++;
                            end
                            seg      = SEG_MESSAGE;
                            seg_left = user_len;
                        end else begin
                            close_packet();
                        end
                    end
                    default: close_packet();
                endcase
            end
        endfunction

        // Returns 1 when the item starts a packet or lands in an open segment.
        function bit frame_item(t_in_item it);
            logic [1:0] q;
            logic [7:0] flags;
            int         rem_len;
            burst = 0;
            q = (it.qos_level > QOS_MAX) ? QOS_MAX : it.qos_level;
            if (it.command == CMD_RESERVED)
                return 1'b0;
            if (it.command == CMD_DATA) begin
                if (seg == SEG_IDLE || seg_left == 0)
                    return 1'b0;
                emit(it.data_byte);
                seg_left--;
                advance_segments();
                return 1'b1;
            end
            emitted  = '0;
            seg      = SEG_IDLE;
            seg_left = '0;
            kind     = it.command;
            qos_held = q;
            user_len = it.len_b;
            pass_len = it.len_c;
            case (it.command)
                CMD_CONNECT: begin
                    rem_len = 12 + int'(it.len_a);
                    flags   = FLAG_CLEAN;
                    if (it.len_b > 0) begin
                        rem_len += 2 + int'(it.len_b);
                        flags   |= FLAG_USER;
                    end
                    if (it.len_c > 0) begin
                        rem_len += 2 + int'(it.len_c);
                        flags   |= FLAG_PASS;
                    end
                    emit(TYPE_CONNECT);
                    emit_rem_len(rem_len);
                    emit(NAME_LEN_HI);
                    emit(NAME_LEN_LO);
                    emit(CHAR_M);
                    emit(CHAR_Q);
                    emit(CHAR_T);
                    emit(CHAR_T);
                    emit(PROTO_LEVEL);
                    emit(flags);
                    emit16(keep_alive);
                    emit16(it.len_a);
                    seg      = SEG_CLIENT_ID;
                    seg_left = it.len_a;
                end
                CMD_SUBSCRIBE, CMD_UNSUBSCRIBE: begin
                    if (it.command == CMD_SUBSCRIBE) begin
                        emit(TYPE_SUBSCRIBE);
                        emit_rem_len(5 + int'(it.len_a));
                    end else begin
                        emit(TYPE_UNSUBSCRIBE);
                        emit_rem_len(4 + int'(it.len_a));
                    end
                    emit16(sub_id);
                    emit16(it.len_a);
                    seg      = SEG_TOPIC;
                    seg_left = it.len_a;
                end
                CMD_PUBLISH: begin
                    emit(TYPE_PUBLISH | {5'd0, q, 1'b0});
                    emit_rem_len(2 + int'(it.len_a) + (q > 0 ? 2 : 0) + int'(it.len_b));
                    emit16(it.len_a);
                    seg      = SEG_TOPIC;
                    seg_left = it.len_a;
                end
                CMD_PINGREQ: begin
                    emit(TYPE_PINGREQ);
                    emit(REM_LEN_NONE);
                    close_packet();
                    return 1'b1;
                end
                default: begin
                    emit(TYPE_DISCONNECT);
                    emit(REM_LEN_NONE);
                    close_packet();
                    return 1'b1;
                end
            endcase
            advance_segments();
            return 1'b1;
        endfunction

        function void check(t_out_item got);
            t_out_item want;
            if (bytes_due.size() == 0) begin
                $error("unexpected byte %0h with no prediction pending", got.out_byte);
                errors++;
                return;
            end
            want = bytes_due.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.last_byte !== want.last_byte) begin
                $error("last_byte: expected %0b, got %0b", want.last_byte, got.last_byte);
                errors++;
            end
            if (got.packet_length !== want.packet_length) begin
                $error("packet_length: expected %0d, got %0d",
                       want.packet_length, got.packet_length);
                errors++;
            end
            matched++;
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   push        = 1'b0;
    logic                   full;
    t_in_item               i_item      = '0;
    logic                   pop         = 1'b0;
    logic                   empty;
    t_out_item              o_result;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    framer_scoreboard books = new();
    int               sender_idle_pct = 0;
    int               recv_stall_pct  = 0;
    int               framed_items    = 0;
    int               dropped_items   = 0;

    mqtt_control_packet_framer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .pop         (pop),
        .empty       (empty),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        bit        took;
        t_out_item got;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            took = pop && !empty;
            got  = o_result;
            @(posedge i_clk);
            if (took)
                books.check(got);
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_in_item random_fill();
        t_in_item it;
        it.command   = 3'($urandom);
        it.len_a     = 16'($urandom);
        it.len_b     = 16'($urandom);
        it.len_c     = 16'($urandom);
        it.qos_level = 2'($urandom);
        it.data_byte = 8'($urandom);
        return it;
    endfunction

    task automatic push_item(input t_in_item it);
        int gap;
        bit took;
        gap = 0;
        while (gap < 50 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do begin
            @(negedge i_clk);
            took = !full;
            @(posedge i_clk);
        end while (!took);
        if (books.frame_item(it))
            framed_items++;
        else
            dropped_items++;
    endtask

    task automatic send_start(input logic [2:0] cmd, input logic [15:0] a,
                              input logic [15:0] b, input logic [15:0] c,
                              input logic [1:0] q);
        t_in_item it;
        it           = random_fill();
        it.command   = cmd;
        it.len_a     = a;
        it.len_b     = b;
        it.len_c     = c;
        it.qos_level = q;
        push_item(it);
    endtask

    task automatic send_data(input logic [7:0] value);
        t_in_item it;
        it           = random_fill();
        it.command   = CMD_DATA;
        it.data_byte = value;
        push_item(it);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (books.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] keep_alive, input logic [15:0] sub_id);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_KEEP_ALIVE;
        i_cfg_wdata <= keep_alive;
        @(posedge i_clk);
        books.set_register(CFG_KEEP_ALIVE, keep_alive);
        i_cfg_index <= CFG_SUB_ID;
        i_cfg_wdata <= sub_id;
        @(posedge i_clk);
        books.set_register(CFG_SUB_ID, sub_id);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_packet();
        int         pick;
        int         total;
        int         feed;
        int         a;
        int         b;
        int         c;
        logic [2:0] cmd;
        logic [1:0] q;
        pick = $urandom_range(99);
        a    = $urandom_range(0, 6);
        b    = $urandom_range(0, 6);
        c    = $urandom_range(0, 6);
        q    = 2'($urandom);
        if (pick < 5) begin
            if ($urandom_range(1))
                send_start(CMD_RESERVED, 16'($urandom), 16'($urandom), 16'($urandom), q);
            else
                send_data(8'($urandom));
            return;
        end
        if (pick < 9) begin
            send_start(3'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                       16'($urandom), q);
            repeat ($urandom_range(0, 3)) send_data(8'($urandom));
            return;
        end
        if (pick < 35)
            cmd = CMD_CONNECT;
        else if (pick < 50)
            cmd = CMD_SUBSCRIBE;
        else if (pick < 60)
            cmd = CMD_UNSUBSCRIBE;
        else if (pick < 86)
            cmd = CMD_PUBLISH;
        else if (pick < 93)
            cmd = CMD_PINGREQ;
        else
            cmd = CMD_DISCONNECT;
        if (cmd == CMD_CONNECT) begin
            if ($urandom_range(99) < 30)
                b = 0;
            if ($urandom_range(99) < 30)
                c = 0;
            total = a + b + c;
        end else if (cmd == CMD_PUBLISH) begin
            total = a + b;
        end else if (cmd == CMD_SUBSCRIBE || cmd == CMD_UNSUBSCRIBE) begin
            total = a;
        end else begin
            total = 0;
        end
        send_start(cmd, 16'(a), 16'(b), 16'(c), q);
        feed = total;
        pick = $urandom_range(99);
        if (pick < 8 && total > 0)
            feed = $urandom_range(0, total - 1);
        else if (pick < 16)
            feed = total + $urandom_range(1, 3);
        repeat (feed) send_data(8'($urandom));
    endtask

    task automatic run_until(input int target);
        while (framed_items < target)
            random_packet();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_data(8'hFF);
        send_start(CMD_RESERVED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
        send_start(CMD_PINGREQ, 16'h0000, 16'h0000, 16'h0000, 2'd0);
        send_start(CMD_DISCONNECT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
        send_start(CMD_CONNECT, 16'h0000, 16'h0000, 16'h0000, 2'd0);
        send_start(CMD_CONNECT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd0);
        send_start(CMD_SUBSCRIBE, 16'h0000, 16'hFFFF, 16'hFFFF, 2'd3);
        send_start(CMD_UNSUBSCRIBE, 16'h0000, 16'h0000, 16'h0000, 2'd1);
        send_start(CMD_PUBLISH, 16'h0000, 16'h0000, 16'h0000, 2'd0);
        send_start(CMD_PUBLISH, 16'h0000, 16'h0000, 16'hFFFF, 2'd1);
        send_start(CMD_PUBLISH, 16'h0002, 16'h0001, 16'h0000, 2'd3);
        send_data(8'h00);
        send_data(8'hFF);
        send_data(8'hA5);
        send_data(8'h5A);
        send_start(CMD_CONNECT, 16'h0001, 16'h0001, 16'h0001, 2'd2);
        send_data(8'h55);
        send_data(8'hAA);
        send_data(8'h0F);
        send_start(CMD_SUBSCRIBE, 16'hFFFF, 16'h0000, 16'h0000, 2'd2);
        send_start(CMD_SUBSCRIBE, 16'h0001, 16'h0000, 16'h0000, 2'd1);
        send_data(8'hF0);

        settle();
        configure(16'h0000, 16'h0000);
        sender_idle_pct = 73;
        recv_stall_pct  = 0;
        run_until(75);
        settle();
        run_until(130);

        settle();
        configure(16'hFFFF, 16'hFFFF);
        sender_idle_pct = 0;
        recv_stall_pct  = 73;
        run_until(245);

        settle();
        configure(16'($urandom), 16'($urandom));
        sender_idle_pct = 14;
        recv_stall_pct  = 14;
        run_until(360);

        settle();
        configure(16'($urandom), 16'($urandom));
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        run_until(470);

        settle();
        $display("Framed %0d start and data items (%0d more dropped or ignored).",
                 framed_items, dropped_items);
        $display("Compared %0d packet bytes across five register settings, %0d mismatches.",
                 books.matched, books.errors);
        if (books.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/mcpf_pkg.sv
rtl/mcpf_front.sv
rtl/mcpf_job_fifo.sv
rtl/mcpf_back.sv
rtl/mqtt_control_packet_framer.sv
verif/tb_mqtt_control_packet_framer.sv
